/* rtl/core/mau256_pkg.sv */
// package for the p-256 modular arithmetic unit
// holds moduli, operation codes and sequencer states; no dependencies
`timescale 1ns / 1ps
package mau256_pkg;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned NUM_W  = 256;
    localparam int unsigned PROD_W = 512;

    localparam logic [NUM_W-1:0] PRIME_P =
        256'hffffffff00000001000000000000000000000000ffffffffffffffffffffffff;
    localparam logic [NUM_W-1:0] ORDER_N =
        256'hffffffff00000000ffffffffffffffffbce6faada7179e84f3b9cac2fc632551;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_INV = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDSUB,
        ST_MUL_PP,
        ST_MUL_RED,
        ST_INV_STEP,
        ST_DONE
    } t_state;
endpackage

/* rtl/core/modular_arithmetic_unit_256.sv */
// Add/sub compute the result in the ADDSUB state; multiply forms 64 partial
// products of 32x32 bits, then runs 512 shift-and-subtract reduction steps.
// Inverse runs up to 512 such multiplies through the same unit.
// One transaction at a time; the next is accepted once the result is taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops output valid.
// depends on mau256_pkg
`timescale 1ns / 1ps
module modular_arithmetic_unit_256 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_modulus_select,
    input  logic [63:0] i_operand_a_word0,
    input  logic [63:0] i_operand_a_word1,
    input  logic [63:0] i_operand_a_word2,
    input  logic [63:0] i_operand_a_word3,
    input  logic [63:0] i_operand_b_word0,
    input  logic [63:0] i_operand_b_word1,
    input  logic [63:0] i_operand_b_word2,
    input  logic [63:0] i_operand_b_word3,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_word0,
    output logic [63:0] o_result_word1,
    output logic [63:0] o_result_word2,
    output logic [63:0] o_result_word3
);
    localparam int unsigned N = mau256_pkg::NUM_W;
    localparam int unsigned P = mau256_pkg::PROD_W;

    mau256_pkg::t_state r_state, n_state;
    logic [1:0]   r_op, n_op;
    logic [N-1:0] r_m, n_m;
    logic [N-1:0] r_a, n_a;       // multiplicand / base
    logic [N-1:0] r_b, n_b;       // multiplier / result accumulator
    logic [N-1:0] r_x, n_x;       // mul operand x
    logic [N-1:0] r_y, n_y;       // mul operand y
    logic [P-1:0] r_prod, n_prod;
    logic [N-1:0] r_acc, n_acc;
    logic [N-1:0] r_res, n_res;
    logic [5:0]   r_pp, n_pp;     // partial product index i*8+j
    logic [8:0]   r_bit, n_bit;
    logic [9:0]   r_ebit, n_ebit; // inverse: exponent bit, bit 0 = which mul
    logic         r_oval, n_oval;

    // shared 32x32 multiplier with accumulate into the product
    logic [31:0]  pp_x, pp_y;
    logic [63:0]  pp_m;
    logic [P-1:0] pp_sh, pp_sum;
    assign pp_x  = r_x[{r_pp[5:3], 5'd0} +: 32];
    assign pp_y  = r_y[{r_pp[2:0], 5'd0} +: 32];
    assign pp_m  = pp_x * pp_y;
    assign pp_sh = {{(P-64){1'b0}}, pp_m} << {({1'b0, r_pp[5:3]} + {1'b0, r_pp[2:0]}), 5'd0};
    assign pp_sum = r_prod + pp_sh;

    // shared add / compare / subtract
    logic [N:0]   shl, shl_sub;
    logic [N:0]   add_s, add_sc;
    logic [N:0]   sub_d;
    logic [N-1:0] sub_c;
    logic [N-1:0] e_val;
    assign shl     = {r_acc, r_prod[r_bit]};
    assign shl_sub = shl - {1'b0, r_m};
    assign add_s   = {1'b0, r_a} + {1'b0, r_b};
    assign add_sc  = add_s - {1'b0, r_m};
    assign sub_d   = {1'b0, r_a} - {1'b0, r_b};
    assign sub_c   = sub_d[N-1:0] + r_m;
    assign e_val   = r_m - N'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mau256_pkg::ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
        r_op <= n_op; r_m <= n_m; r_a <= n_a; r_b <= n_b; r_x <= n_x; r_y <= n_y;
        r_prod <= n_prod; r_acc <= n_acc; r_res <= n_res;
        r_pp <= n_pp; r_bit <= n_bit; r_ebit <= n_ebit;
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_m = r_m; n_a = r_a; n_b = r_b;
        n_x = r_x; n_y = r_y; n_prod = r_prod; n_acc = r_acc; n_res = r_res;
        n_pp = r_pp; n_bit = r_bit; n_ebit = r_ebit; n_oval = r_oval;
        o_ready = 1'b0;
        case (r_state)
            mau256_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op = i_operation;
                    n_m  = i_modulus_select ? mau256_pkg::ORDER_N : mau256_pkg::PRIME_P;
                    n_a  = {i_operand_a_word3, i_operand_a_word2,
                            i_operand_a_word1, i_operand_a_word0};
                    n_b  = {i_operand_b_word3, i_operand_b_word2,
                            i_operand_b_word1, i_operand_b_word0};
                    n_pp = '0; n_prod = '0; n_acc = '0; n_bit = 9'(P-1); n_ebit = '0;
                    case (mau256_pkg::t_op'(i_operation))
                        mau256_pkg::OP_ADD, mau256_pkg::OP_SUB: n_state = mau256_pkg::ST_ADDSUB;
                        mau256_pkg::OP_MUL: begin
                            n_x = n_a; n_y = n_b; n_state = mau256_pkg::ST_MUL_PP;
                        end
                        default: begin
                            n_b = N'(1); n_state = mau256_pkg::ST_INV_STEP;
                        end
                    endcase
                end
            end
            mau256_pkg::ST_ADDSUB: begin
                if (r_op == mau256_pkg::OP_ADD)
                    n_res = (add_s[N] || !add_sc[N]) ? add_sc[N-1:0] : add_s[N-1:0];
                else
                    n_res = sub_d[N] ? sub_c : sub_d[N-1:0];
                n_state = mau256_pkg::ST_DONE; n_oval = 1'b1;
            end
            mau256_pkg::ST_INV_STEP: begin
                // even step: res*base if exponent bit set; odd step: base*base
                n_pp = '0; n_prod = '0; n_acc = '0; n_bit = 9'(P-1);
                if (r_ebit == 10'(2*N)) begin
                    n_res = r_b; n_state = mau256_pkg::ST_DONE; n_oval = 1'b1;
                end else if (r_ebit[0]) begin
                    n_x = r_a; n_y = r_a; n_state = mau256_pkg::ST_MUL_PP;
                end else if (e_val[r_ebit[8:1]]) begin
                    n_x = r_b; n_y = r_a; n_state = mau256_pkg::ST_MUL_PP;
                end else begin
                    n_ebit = r_ebit + 10'd1;
                end
            end
            mau256_pkg::ST_MUL_PP: begin
                n_prod = pp_sum;
                n_pp = r_pp + 6'd1;
                if (r_pp == 6'd63) n_state = mau256_pkg::ST_MUL_RED;
            end
            mau256_pkg::ST_MUL_RED: begin
                n_acc = (shl[N] || !shl_sub[N]) ? shl_sub[N-1:0] : shl[N-1:0];
                n_bit = r_bit - 9'd1;
                if (r_bit == '0) begin
                    if (r_op == mau256_pkg::OP_MUL) begin
                        n_res = n_acc; n_state = mau256_pkg::ST_DONE; n_oval = 1'b1;
                    end else begin
                        if (r_ebit[0]) n_a = n_acc;
                        else n_b = n_acc;
                        n_ebit = r_ebit + 10'd1;
                        n_state = mau256_pkg::ST_INV_STEP;
                    end
                end
            end
            mau256_pkg::ST_DONE: begin
                if (i_ready) begin
                    n_oval = 1'b0; n_state = mau256_pkg::ST_IDLE;
                end
            end
            default: n_state = mau256_pkg::ST_IDLE;
        endcase
    end

    assign o_valid        = r_oval;
    assign o_result_word0 = r_res[63:0];
    assign o_result_word1 = r_res[127:64];
    assign o_result_word2 = r_res[191:128];
    assign o_result_word3 = r_res[255:192];

`ifndef SYNTHESIS
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == (r_state == mau256_pkg::ST_DONE)) else $error("valid/state mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_res)) else $error("result changed while stalled");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while result pending");
    a_pp_to_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mau256_pkg::ST_MUL_PP && r_pp == 6'd63 |=> r_state == mau256_pkg::ST_MUL_RED)
        else $error("reduction did not follow product");
`endif
endmodule
